// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sjtpg_pkg.sv =====
package sjtpg_pkg;

  localparam int MAX_ELEMS = 16;
  localparam int ELEM_BITS = 8;
  localparam int PERM_W    = 45;
  localparam int POS_W     = 4;
  localparam int REQ_W     = 2;

  localparam int IDX_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMS + 1);

  localparam int IN_TDATA_W  = ((ELEM_BITS + 7) / 8) * 8;
  localparam int OUT_PAY_W   = POS_W + ELEM_BITS + PERM_W;
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR,
    REQ_APPEND,
    REQ_RESTART,
    REQ_STEP
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_RST,
    ST_SCAN,
    ST_FLIP,
    ST_SWAP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EXH
  } state_t;

  // One slot of the working order: direction (1 = facing right) and value.
  typedef struct packed {
    logic                 dir;
    logic [ELEM_BITS-1:0] val;
  } entry_t;

endpackage

// ===== hw/rtl/sjt_permutation_generator_top.sv =====
// Steinhaus-Johnson-Trotter permutation generator.
// Input channel (in_*): one beat per request. in_tuser holds the request kind
// (clear, append, restart, step), in_tdata the signed element of an append.
// Output channel (out_*): a step emits the whole permutation, one beat per
// element, with out_tlast on the final beat; out_tuser flags an exhausted
// result (single beat, position 0, value 0, unchanged counter).
// The working order (value plus direction) and the sorted copy each live in
// a 16-entry synchronous RAM with a registered read port.
// Sequence from one accepted request to the next: clear finishes on
// acceptance; restart runs a copy sweep sorted -> working. append: accept,
// a read and a compare per shifted element, a write to place it, then the
// restart sweep. step: accept, mobility scan, direction flip, swap, then
// a RAM read and an output load per beat, the emit pace bound by the
// single read port of the working-order RAM.
// in_tready is high only while the sequencer is idle; the last output beat
// sits in the output register, so the next request is taken while it waits.
// When the receiver stalls, the beat is held and the sequencer waits.
// Reset (rst_n low, synchronous) empties the store and zeroes the counter;
// no RAM clearing pass is needed since only entries below the count are read.
module sjt_permutation_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sjtpg_pkg::IN_TDATA_W-1:0]  in_tdata,   // elem_value
  input  logic [sjtpg_pkg::REQ_W-1:0]       in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sjtpg_pkg::OUT_TDATA_W-1:0] out_tdata,  // position, out_value, perm_number
  output logic                             out_tlast,
  output logic [0:0]                       out_tuser   // exhausted
);
  import sjtpg_pkg::*;

  // Sequencer and bookkeeping.
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PERM_W-1:0]    perm_r, perm_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [ELEM_BITS-1:0] ins_val_r, ins_val_nxt;
  logic [ELEM_BITS-1:0] prev_val_r, prev_val_nxt;
  logic                 prev_dir_r, prev_dir_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [ELEM_BITS-1:0] best_val_r, best_val_nxt;
  logic                 best_dir_r, best_dir_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [ELEM_BITS-1:0] out_val_r, out_val_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_exh_r, out_exh_nxt;
  logic [PERM_W-1:0]    out_perm_r, out_perm_nxt;

  // RAMs.
  entry_t               work_mem [MAX_ELEMS];
  logic [ELEM_BITS-1:0] sort_mem [MAX_ELEMS];
  entry_t               work_rd_r;
  logic [ELEM_BITS-1:0] sort_rd_r;
  logic                 work_re, work_we, sort_re, sort_we;
  logic [IDX_W-1:0]     work_raddr, work_waddr, sort_raddr, sort_waddr;
  entry_t               work_wdata;
  logic [ELEM_BITS-1:0] sort_wdata;

  // Shared control terms.
  logic                 in_fire;
  logic                 rd_more;
  logic                 sweep_done;
  logic                 can_load;
  logic                 emit_last;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     data_idx;
  logic [IDX_W-1:0]     other_idx;
  logic                 cand_left, cand_right;
  logic                 ins_shift;
  req_t                 req;

  assign req        = req_t'(in_tuser);
  assign in_fire    = in_tvalid && in_tready;
  assign rd_more    = idx_r < count_r;
  assign sweep_done = !rd_more && !pend_r;
  assign can_load   = !out_valid_r || out_tready;
  assign emit_last  = idx_r == CNT_W'(count_r - 1'b1);
  assign rd_idx     = idx_r[IDX_W-1:0];
  assign data_idx   = IDX_W'(idx_r - 1'b1);
  assign other_idx  = best_dir_r ? IDX_W'(best_idx_r + 1'b1) : IDX_W'(best_idx_r - 1'b1);
  assign ins_shift  = $signed(sort_rd_r) > $signed(ins_val_r);

  // Mobility of the element pair seen in the scan window: the previous entry
  // faces right into a smaller one, or the new entry faces left into a
  // smaller one. Both cannot hold at once.
  assign cand_right = pend_r && (idx_r > CNT_W'(1)) && prev_dir_r &&
                      ($signed(prev_val_r) > $signed(work_rd_r.val));
  assign cand_left  = pend_r && (idx_r > CNT_W'(1)) && !work_rd_r.dir &&
                      ($signed(work_rd_r.val) > $signed(prev_val_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (req)
            REQ_CLEAR:   state_nxt = ST_IDLE;
            REQ_APPEND:  state_nxt = (count_r < CNT_W'(MAX_ELEMS)) ? ST_INS_RD : ST_IDLE;
            REQ_RESTART: state_nxt = ST_RST;
            REQ_STEP:    state_nxt = ST_SCAN;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD:  state_nxt = (idx_r == '0) ? ST_RST : ST_INS_CMP;
      ST_INS_CMP: state_nxt = ins_shift ? ST_INS_RD : ST_RST;
      ST_RST:     state_nxt = sweep_done ? ST_IDLE : ST_RST;
      ST_SCAN: begin
        if (sweep_done) begin
          state_nxt = found_r ? ST_FLIP : ST_EXH;
        end
      end
      ST_FLIP:    state_nxt = sweep_done ? ST_SWAP : ST_FLIP;
      ST_SWAP:    state_nxt = ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (can_load) begin
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EXH:     state_nxt = can_load ? ST_IDLE : ST_EXH;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    count_nxt     = count_r;
    perm_nxt      = perm_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    ins_val_nxt   = ins_val_r;
    prev_val_nxt  = prev_val_r;
    prev_dir_nxt  = prev_dir_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    best_dir_nxt  = best_dir_r;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_exh_nxt   = out_exh_r;
    out_perm_nxt  = out_perm_r;
    out_valid_nxt = out_valid_r && !out_tready;
    work_re       = 1'b0;
    work_raddr    = rd_idx;
    work_we       = 1'b0;
    work_waddr    = data_idx;
    work_wdata    = '{dir: 1'b0, val: sort_rd_r};
    sort_re       = 1'b0;
    sort_raddr    = rd_idx;
    sort_we       = 1'b0;
    sort_waddr    = rd_idx;
    sort_wdata    = ins_val_r;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        idx_nxt   = '0;
        found_nxt = 1'b0;
        if (in_fire) begin
          unique case (req)
            REQ_CLEAR: begin
              count_nxt = '0;
              perm_nxt  = '0;
            end
            REQ_APPEND: begin
              if (count_r < CNT_W'(MAX_ELEMS)) begin
                ins_val_nxt = in_tdata[ELEM_BITS-1:0];
                idx_nxt     = count_r;
                count_nxt   = CNT_W'(count_r + 1'b1);
                perm_nxt    = '0;
              end
            end
            REQ_RESTART: perm_nxt = '0;
            REQ_STEP:    ;
            default:     ;
          endcase
        end
      end
      ST_INS_RD: begin
        if (idx_r == '0) begin
          // Insertion point reached at the bottom.
          sort_we = 1'b1;
        end else begin
          sort_re    = 1'b1;
          sort_raddr = IDX_W'(idx_r - 1'b1);
        end
      end
      ST_INS_CMP: begin
        sort_we = 1'b1;
        if (ins_shift) begin
          sort_wdata = sort_rd_r;
          idx_nxt    = CNT_W'(idx_r - 1'b1);
        end else begin
          idx_nxt = '0;
        end
      end
      ST_RST: begin
        // Read sorted entry i while writing entry i-1 back facing left.
        sort_re  = rd_more;
        pend_nxt = rd_more;
        if (rd_more) idx_nxt = CNT_W'(idx_r + 1'b1);
        work_we  = pend_r;
      end
      ST_SCAN: begin
        work_re  = rd_more;
        pend_nxt = rd_more;
        if (rd_more) idx_nxt = CNT_W'(idx_r + 1'b1);
        if (pend_r) begin
          prev_val_nxt = work_rd_r.val;
          prev_dir_nxt = work_rd_r.dir;
        end
        // Strictly greater replaces, so the lowest index wins a tie.
        if (cand_right &&
            (!found_r || ($signed(prev_val_r) > $signed(best_val_r)))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = IDX_W'(idx_r - 2'd2);
          best_val_nxt = prev_val_r;
          best_dir_nxt = 1'b1;
        end else if (cand_left &&
                     (!found_r || ($signed(work_rd_r.val) > $signed(best_val_r)))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = data_idx;
          best_val_nxt = work_rd_r.val;
          best_dir_nxt = 1'b0;
        end
        if (sweep_done) idx_nxt = '0;
      end
      ST_FLIP: begin
        // Flip larger entries; the neighbor lands in the mobile slot now,
        // the mobile entry itself is written in the swap cycle.
        work_re    = rd_more;
        pend_nxt   = rd_more;
        if (rd_more) idx_nxt = CNT_W'(idx_r + 1'b1);
        work_wdata = '{dir: work_rd_r.dir ^ ($signed(work_rd_r.val) > $signed(best_val_r)),
                       val: work_rd_r.val};
        work_we    = pend_r && (data_idx != best_idx_r);
        work_waddr = (data_idx == other_idx) ? best_idx_r : data_idx;
      end
      ST_SWAP: begin
        work_we    = 1'b1;
        work_waddr = other_idx;
        work_wdata = '{dir: best_dir_r, val: best_val_r};
        perm_nxt   = perm_r + 1'b1;
        idx_nxt    = '0;
      end
      ST_EMIT_RD: begin
        work_re = 1'b1;
      end
      ST_EMIT_LD: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(idx_r);
          out_val_nxt   = work_rd_r.val;
          out_last_nxt  = emit_last;
          out_exh_nxt   = 1'b0;
          out_perm_nxt  = perm_r;
          idx_nxt       = CNT_W'(idx_r + 1'b1);
        end
      end
      ST_EXH: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_val_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_exh_nxt   = 1'b1;
          out_perm_nxt  = perm_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      perm_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      perm_r      <= perm_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_val_r  <= ins_val_nxt;
    prev_val_r <= prev_val_nxt;
    prev_dir_r <= prev_dir_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    best_dir_r <= best_dir_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_exh_r  <= out_exh_nxt;
    out_perm_r <= out_perm_nxt;
  end

  // Working order RAM: value plus direction.
  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_waddr] <= work_wdata;
    if (work_re) work_rd_r <= work_mem[work_raddr];
  end

  // Sorted copy RAM.
  always_ff @(posedge clk) begin
    if (sort_we) sort_mem[sort_waddr] <= sort_wdata;
    if (sort_re) sort_rd_r <= sort_mem[sort_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_perm_r, out_val_r, out_pos_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_exh_r;

endmodule

// ===== hw/rtl/sjtpg_checker.sv =====
`include "assert_macros.svh"

module sjtpg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [sjtpg_pkg::REQ_W-1:0]       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sjtpg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic [0:0]                       out_tuser
);
  import sjtpg_pkg::*;

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Hold a stalled beat.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output beat changed")

  // An exhausted beat is a one-beat run at position zero with value zero.
  `ASSERT_IMP(a_exh_shape, clk, rst_n, out_tvalid && out_tuser[0], out_tlast && (out_tdata[POS_W+ELEM_BITS-1:0] == '0), "exhausted beat malformed")

  // A step keeps the request side closed on the following cycle.
  `ASSERT_NXT(a_step_busy, clk, rst_n, in_fire && (in_tuser == REQ_STEP), !in_tready, "request taken right after a step")

  // Clear, append and restart never produce a beat.
  `ASSERT_NXT(a_no_spurious, clk, rst_n, in_fire && (in_tuser != REQ_STEP) && !out_tvalid, !out_tvalid, "beat produced by a non-step request")

endmodule

bind sjt_permutation_generator_top sjtpg_checker u_sjtpg_checker (.*);
